>>> src/aclb_pkg.sv
// Package for the atom cell-list binning block: state codes, widths and constants.
// No dependencies; used by the divider and the top level of the block.
package aclb_pkg;

    // Fixed field widths.
    localparam int PosW   = 25;
    localparam int EdgeW  = 20;
    localparam int GridW  = 13;
    localparam int CellW  = 12;
    localparam int SlotW  = 6;
    localparam int DivW   = 26;
    localparam int CntW   = 7;
    localparam int GridSat = 4096;

    // Control sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_GRID,
        ST_GDIV,
        ST_GCHK,
        ST_ADIV,
        ST_ALIN,
        ST_ARD,
        ST_AWR,
        ST_CLR
    } t_state;

endpackage

>>> src/aclb_divider.sv
// Restoring divider, one quotient bit per cycle, for non-negative operands.
// Depends on aclb_pkg for the operand widths.
module aclb_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [aclb_pkg::DivW-1:0] i_num,
    input  logic [aclb_pkg::EdgeW-1:0] i_den,
    output logic                     o_done,
    output logic [aclb_pkg::DivW-1:0] o_quo
);
    import aclb_pkg::*;

    logic [DivW-1:0]   r_quo;
    logic [EdgeW:0]    r_rem;
    logic [EdgeW-1:0]  r_den;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [EdgeW+1:0]  w_trial;
    logic [EdgeW:0]    w_shift;

    // Shift one numerator bit into the partial remainder and try a subtraction.
    assign w_shift = {r_rem[EdgeW-1:0], r_quo[DivW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DivW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // Data path.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[EdgeW+1]) begin
                r_rem <= w_trial[EdgeW:0];
                r_quo <= {r_quo[DivW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[DivW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> src/atom_cell_list_binning_top.sv
// Top level of the atom cell-list binning block: atom store, bounding box,
// cell counter memory and sequencer. Depends on aclb_pkg and aclb_divider.
//
// Use: an atom transfer is taken when i_start is high and o_busy is low.
// The atom with i_batch_end set starts binning and o_busy rises. The three
// axis cell counts are found with one shared bit-serial divider, then the
// grid is checked in ST_GCHK. Each stored atom then passes through a read
// of the atom store, the three axis divisions, forming the linear index and
// reading its counter, and writing the counter back. The shared divider
// sets the cost of each atom. On an overflowing grid an atom skips the
// divisions and leaves the counters alone. Each result is on the o_ ports
// for one cycle marked by o_valid; the receiver cannot stall. After the
// last result the counter memory is cleared in a pass with o_busy still
// high; the same pass runs after reset, so o_busy stays high until it ends
// once reset is released. i_cfg_we writes the cell edge (reset 1000);
// write it only while idle.
module atom_cell_list_binning_top #(
    parameter int MAX_ATOMS = 64,
    parameter int MAX_CELLS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [aclb_pkg::EdgeW-1:0]  i_cfg_wdata,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [aclb_pkg::PosW-1:0] i_pos_x,
    input  logic signed [aclb_pkg::PosW-1:0] i_pos_y,
    input  logic signed [aclb_pkg::PosW-1:0] i_pos_z,
    input  logic                        i_batch_end,
    output logic                        o_valid,
    output logic [5:0]                  o_atom_index,
    output logic [aclb_pkg::CellW-1:0]  o_cell_index,
    output logic [aclb_pkg::SlotW-1:0]  o_slot_in_cell,
    output logic [aclb_pkg::GridW-1:0]  o_grid_nx,
    output logic [aclb_pkg::GridW-1:0]  o_grid_ny,
    output logic [aclb_pkg::GridW-1:0]  o_grid_nz,
    output logic signed [aclb_pkg::PosW-1:0] o_origin_x,
    output logic signed [aclb_pkg::PosW-1:0] o_origin_y,
    output logic signed [aclb_pkg::PosW-1:0] o_origin_z,
    output logic                        o_grid_overflow,
    output logic                        o_run_end
);
    import aclb_pkg::*;

    localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int NW  = $clog2(MAX_ATOMS + 1);
    localparam int CAW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNW = $clog2(MAX_CELLS + 1);

    // Memories.
    logic [3*PosW-1:0] atom_mem [MAX_ATOMS];
    logic [CntW-1:0]   cnt_mem  [MAX_CELLS];

    t_state r_state, n_state;
    logic [EdgeW-1:0]  r_edge;
    logic [NW-1:0]     r_loaded;
    logic signed [PosW-1:0] r_min [3];
    logic signed [PosW-1:0] r_max [3];
    logic [1:0]        r_axis;
    logic [DivW-1:0]   r_n [3];
    logic [2*CNW-1:0]  r_nxy;
    logic              r_ovf;
    logic [AW-1:0]     r_idx;
    logic [3*PosW-1:0] r_atom;
    logic [DivW-1:0]   r_c [3];
    logic [31:0]       r_lin;
    logic [CAW-1:0]    r_caddr;
    logic [CntW-1:0]   r_cnt_rd;
    logic [CNW-1:0]    r_clr;
    logic              r_go;
    logic              r_out_v;
    logic [5:0]        r_o_atom;
    logic [CellW-1:0]  r_o_cell;
    logic [SlotW-1:0]  r_o_slot;
    logic              r_o_end;

    logic              w_acc;
    logic              w_done;
    logic [DivW-1:0]   w_quo;
    logic [DivW-1:0]   w_num;
    logic [EdgeW-1:0]  w_den;
    logic signed [PosW-1:0] w_pos [3];
    logic signed [PosW-1:0] w_atom_ax;
    logic [PosW:0]     w_diff;
    logic [3*CNW-1:0]  w_nxyz;
    logic [31:0]       w_lin;
    logic              w_lin_ok;

    assign w_acc  = i_start && (r_state == ST_LOAD);
    assign w_den  = (r_edge == '0) ? EdgeW'(1) : r_edge;
    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    // Divider operand: box range in the grid phase, atom offset later.
    always_comb begin
        unique case (r_axis)
            2'd0:    w_atom_ax = r_atom[PosW-1:0];
            2'd1:    w_atom_ax = r_atom[2*PosW-1:PosW];
            default: w_atom_ax = r_atom[3*PosW-1:2*PosW];
        endcase
        if (r_state == ST_GRID || r_state == ST_GDIV)
            w_diff = {r_max[r_axis][PosW-1], r_max[r_axis]}
                   - {r_min[r_axis][PosW-1], r_min[r_axis]};
        else
            w_diff = {w_atom_ax[PosW-1], w_atom_ax}
                   - {r_min[r_axis][PosW-1], r_min[r_axis]};
        w_num = DivW'(w_diff);
    end

    aclb_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_go),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quo  (w_quo)
    );

    // Total cell count for the overflow check; nx*ny is registered beforehand.
    assign w_nxyz = (3*CNW)'(r_nxy) * (3*CNW)'(r_n[2][CNW-1:0]);

    // Linear index, bounded by the grid size whenever the grid fits.
    assign w_lin = 32'(r_c[0]) + 32'(r_c[1]) * 32'(r_n[0]) + 32'(r_c[2]) * 32'(r_nxy);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (w_acc && i_batch_end) n_state = ST_GRID;
            ST_GRID: n_state = ST_GDIV;
            ST_GDIV: if (w_done) n_state = (r_axis == 2'd2) ? ST_GCHK : ST_GRID;
            ST_GCHK: n_state = (r_loaded == '0) ? ST_CLR : ST_ARD;
            ST_ARD:  n_state = r_ovf ? ST_AWR : ST_ADIV;
            ST_ADIV: if (w_done && r_axis == 2'd2) n_state = ST_ALIN;
            ST_ALIN: n_state = ST_AWR;
            ST_AWR:  n_state = (32'(r_idx) + 1 == 32'(r_loaded)) ? ST_CLR : ST_ARD;
            ST_CLR:  if (32'(r_clr) + 1 >= MAX_CELLS) n_state = ST_LOAD;
            default: n_state = ST_CLR;
        endcase
    end

    assign o_busy = (r_state != ST_LOAD);

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_edge   <= EdgeW'(1000);
            r_loaded <= '0;
            r_clr    <= '0;
            r_axis   <= '0;
            r_go     <= 1'b0;
            r_out_v  <= 1'b0;
            r_idx    <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_go    <= 1'b0;
            r_out_v <= 1'b0;
            if (i_cfg_we) r_edge <= i_cfg_wdata;
            unique case (r_state)
                ST_LOAD: begin
                    r_clr  <= '0;
                    r_axis <= '0;
                    r_idx  <= '0;
                    if (w_acc && 32'(r_loaded) < MAX_ATOMS) begin
                        r_loaded <= r_loaded + NW'(1);
                        for (int a = 0; a < 3; a++) begin
                            if (r_loaded == '0 || w_pos[a] > r_max[a]) r_max[a] <= w_pos[a];
                            if (r_loaded == '0 || w_pos[a] < r_min[a]) r_min[a] <= w_pos[a];
                        end
                    end
                end
                ST_GRID: r_go <= 1'b1;
                ST_GDIV: if (w_done) r_axis <= r_axis + 2'd1;
                ST_GCHK: r_axis <= '0;
                ST_ARD:  begin
                    r_axis <= '0;
                    r_go   <= !r_ovf;
                end
                ST_ADIV: if (w_done && r_axis != 2'd2) begin
                    r_axis <= r_axis + 2'd1;
                    r_go   <= 1'b1;
                end
                ST_ALIN: ;
                ST_AWR:  begin
                    r_out_v <= 1'b1;
                    r_idx   <= r_idx + AW'(1);
                end
                ST_CLR:  begin
                    r_clr    <= r_clr + CNW'(1);
                    r_loaded <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: grid counts, overflow, atom offsets, linear index and result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_GDIV && w_done) r_n[r_axis] <= w_quo + DivW'(1);
        if (r_state == ST_GRID)
            r_nxy <= (2*CNW)'(r_n[0][CNW-1:0]) * (2*CNW)'(r_n[1][CNW-1:0]);
        if (r_state == ST_GCHK)
            r_ovf <= (32'(r_n[0]) > MAX_CELLS) || (32'(r_n[1]) > MAX_CELLS)
                  || (32'(r_n[2]) > MAX_CELLS) || (r_nxy > (2*CNW)'(MAX_CELLS))
                  || (w_nxyz > (3*CNW)'(MAX_CELLS));
        if (r_state == ST_ADIV && w_done) r_c[r_axis] <= w_quo;
        if (r_state == ST_ALIN) begin
            r_lin   <= w_lin;
            r_caddr <= w_lin[CAW-1:0];
        end
        if (r_state == ST_AWR) begin
            r_o_atom <= 6'(r_idx);
            r_o_end  <= (32'(r_idx) + 1 == 32'(r_loaded));
            if (!r_ovf && r_lin < MAX_CELLS) begin
                r_o_cell <= CellW'(r_lin);
                r_o_slot <= SlotW'(r_cnt_rd);
            end else begin
                r_o_cell <= '0;
                r_o_slot <= '0;
            end
        end
    end

    // A counter is only incremented when the grid fits and the index is in range.
    assign w_lin_ok = !r_ovf && (r_lin < MAX_CELLS);

    // Atom store: written while loading, read one entry per atom.
    always_ff @(posedge i_clk) begin
        if (w_acc && 32'(r_loaded) < MAX_ATOMS)
            atom_mem[r_loaded[AW-1:0]] <= {i_pos_z, i_pos_y, i_pos_x};
        r_atom <= atom_mem[r_idx];
    end

    // Cell counters: cleared in CLR, read as the index is formed, written back in AWR.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR)
            cnt_mem[r_clr[CAW-1:0]] <= '0;
        else if (r_state == ST_AWR && w_lin_ok && r_cnt_rd < CntW'(127))
            cnt_mem[r_caddr] <= r_cnt_rd + CntW'(1);
        r_cnt_rd <= cnt_mem[w_lin[CAW-1:0]];
    end

    // Result ports.
    always_comb begin
        o_valid         = r_out_v;
        o_atom_index    = r_o_atom;
        o_cell_index    = r_o_cell;
        o_slot_in_cell  = r_o_slot;
        o_grid_nx       = (r_n[0] > DivW'(GridSat)) ? GridW'(GridSat) : GridW'(r_n[0]);
        o_grid_ny       = (r_n[1] > DivW'(GridSat)) ? GridW'(GridSat) : GridW'(r_n[1]);
        o_grid_nz       = (r_n[2] > DivW'(GridSat)) ? GridW'(GridSat) : GridW'(r_n[2]);
        o_origin_x      = r_min[0];
        o_origin_y      = r_min[1];
        o_origin_z      = r_min[2];
        o_grid_overflow = r_ovf;
        o_run_end       = r_o_end;
    end
endmodule

>>> src/aclb_checker.sv
// Port-level checks for the binning block, bound to the top level.
// Depends only on the top level's ports.
module aclb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_busy,
    input logic o_valid,
    input logic o_grid_overflow,
    input logic [11:0] o_cell_index,
    input logic [5:0] o_slot_in_cell
);
    // Results only appear while the block is binning.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result outside binning");
    // Two results never follow in adjacent cycles.
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("results too close");
    // An overflowing grid gives slot zero.
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grid_overflow) |-> (o_slot_in_cell == 6'd0))
        else $error("slot on overflow");
    // An overflowing grid gives cell index zero.
    a_ovf_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grid_overflow) |-> (o_cell_index == 12'd0))
        else $error("cell index on overflow");
    // The block comes out of reset busy, so transfers are not accepted at first.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy) else $error("idle after reset");
endmodule

bind atom_cell_list_binning_top aclb_checker u_aclb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_grid_overflow(o_grid_overflow),
    .o_cell_index   (o_cell_index),
    .o_slot_in_cell (o_slot_in_cell)
);
